// ===== rtl/ddpj_pkg.sv =====
// Shared types and constants for the DDP period jitter block.
package ddpj_pkg;

    // Result format
    localparam int FRAC_BITS = 16;
    localparam int OUT_W     = 48;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PERIOD    = 2'd0,
        CFG_MAX_PERIOD    = 2'd1,
        CFG_ABSOLUTE_MODE = 2'd2,
        CFG_DROP_MISSING  = 2'd3
    } cfg_idx_t;

    // Mode flags handed to the front end
    typedef struct packed {
        logic absolute_mode;
        logic drop_missing;
    } mode_t;

    // Back end sequencer
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } back_state_t;

endpackage

// ===== rtl/ddpj_front.sv =====
// Front end: takes one period word per cycle while the job queue is not full, and accumulates the sequence totals.
module ddpj_front #(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_COUNT   = 1048576,
    parameter int CNT_W       = 21,
    parameter int DEV_W       = 46,
    parameter int PT_W        = 45,
    parameter int JOB_W       = 138
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] period,
    input  logic                   missing,
    input  logic                   last,
    input  logic [SAMPLE_BITS-1:0] min_period,
    input  logic [SAMPLE_BITS-1:0] max_period,
    input  ddpj_pkg::mode_t        mode,
    output logic                   q_push,
    output logic [JOB_W-1:0]       q_data,
    input  logic                   q_full
);
    import ddpj_pkg::*;

    logic [SAMPLE_BITS-1:0] r0_reg, r0_next, r1_reg, r1_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [DEV_W-1:0]       dev_reg, dev_next;
    logic [PT_W-1:0]        pt_reg, pt_next;
    logic                   saw_reg, saw_next;

    logic                   take;
    logic                   in_range;
    logic [SAMPLE_BITS:0]   outer, twice, dev_step;
    logic [SAMPLE_BITS-1:0] tail;
    logic                   valid_pre;

    assign in_ready = ~q_full;
    assign take     = in_valid & in_ready;

    // Second difference around the centre period
    assign in_range = (r1_reg >= min_period) && (r1_reg <= max_period);
    assign outer    = {1'b0, period} + {1'b0, r0_reg};
    assign twice    = {r1_reg, 1'b0};
    assign dev_step = (outer >= twice) ? (outer - twice) : (twice - outer);

    // Accumulation step
    always_comb
    begin
        r0_next  = r0_reg;
        r1_next  = r1_reg;
        cnt_next = cnt_reg;
        dev_next = dev_reg;
        pt_next  = pt_reg;
        saw_next = saw_reg;
        if (take)
        begin
            if (missing)
            begin
                if (!mode.drop_missing)
                begin
                    saw_next = 1'b1;
                end
            end
            else if (cnt_reg <= CNT_W'(MAX_COUNT))
            begin
                if (cnt_reg == CNT_W'(MAX_COUNT))
                begin
                    // count overflow: park one above the limit
                    cnt_next = CNT_W'(MAX_COUNT + 1);
                end
                else
                begin
                    if (cnt_reg == '0)
                    begin
                        pt_next = pt_reg + PT_W'(period);
                    end
                    else if ((cnt_reg >= CNT_W'(2)) && in_range)
                    begin
                        dev_next = dev_reg + DEV_W'(dev_step);
                        pt_next  = pt_reg + PT_W'(r1_reg);
                    end
                    r0_next  = r1_reg;
                    r1_next  = period;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // Job for the back end on the final word
    assign tail = ((cnt_next >= CNT_W'(2)) && (cnt_next <= CNT_W'(MAX_COUNT)))
                  ? r1_next : '0;
    assign valid_pre = (cnt_next > CNT_W'(3)) && (cnt_next <= CNT_W'(MAX_COUNT))
                       && !saw_next;
    assign q_data = {valid_pre, mode.absolute_mode, cnt_next, dev_next, pt_next, tail};
    assign q_push = take & last;

    // Sequence state, cleared after the final word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_reg  <= '0;
            r1_reg  <= '0;
            cnt_reg <= '0;
            dev_reg <= '0;
            pt_reg  <= '0;
            saw_reg <= 1'b0;
        end
        else if (take && last)
        begin
            r0_reg  <= '0;
            r1_reg  <= '0;
            cnt_reg <= '0;
            dev_reg <= '0;
            pt_reg  <= '0;
            saw_reg <= 1'b0;
        end
        else
        begin
            r0_reg  <= r0_next;
            r1_reg  <= r1_next;
            cnt_reg <= cnt_next;
            dev_reg <= dev_next;
            pt_reg  <= pt_next;
            saw_reg <= saw_next;
        end
    end

endmodule

// ===== rtl/ddpj_queue.sv =====
// Two-entry job queue between front and back end.
module ddpj_queue #(
    parameter int WIDTH = 138
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    import ddpj_pkg::*;

    logic [WIDTH-1:0] entry_reg [0:1];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       fill_reg, fill_next;
    logic             pop;

    assign full      = (fill_reg == 2'd2);
    assign pop_valid = (fill_reg != 2'd0);
    assign pop       = pop_valid & pop_ready;
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Fill level
    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/ddpj_back.sv =====
// Back end: shift-add products, restoring division and the result register.
module ddpj_back #(
    parameter int SAMPLE_BITS = 24,
    parameter int CNT_W       = 21,
    parameter int DEV_W       = 46,
    parameter int PT_W        = 45,
    parameter int NUM_W       = 83,
    parameter int DEN_W       = 66,
    parameter int JOB_W       = 138
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  logic [JOB_W-1:0]            q_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ddpj_pkg::OUT_W-1:0]  jitter_value,
    output logic                        valid_res
);
    import ddpj_pkg::*;

    localparam int ITER_W = $clog2(NUM_W);

    // Job fields
    logic                   j_valid, j_abs;
    logic [CNT_W-1:0]       j_cnt;
    logic [DEV_W-1:0]       j_dev;
    logic [PT_W-1:0]        j_pt;
    logic [SAMPLE_BITS-1:0] j_tail;
    logic [PT_W-1:0]        pt_fin;
    logic                   job_ok;

    back_state_t       state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [CNT_W-1:0]  mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    logic [NUM_W-1:0]  nsh_reg, nsh_next, num_reg, num_next, quo_reg, quo_next;
    logic [DEN_W-1:0]  dsh_reg, dsh_next, den_reg, den_next, rem_reg, rem_next;
    logic              ok_reg, ok_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  jitter_value_reg, jitter_value_next;
    logic              valid_res_reg, valid_res_next;

    logic [DEN_W:0]    trial, trial_diff;
    logic              trial_ge;
    logic              pop, load_out;

    assign {j_valid, j_abs, j_cnt, j_dev, j_pt, j_tail} = q_data;
    assign pt_fin = j_pt + PT_W'(j_tail);
    assign job_ok = j_valid && (j_abs || (pt_fin != '0));

    assign q_ready  = (state_reg == ST_IDLE);
    assign pop      = q_valid & q_ready;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // One restoring division step
    assign trial      = {rem_reg, num_reg[NUM_W-1]};
    assign trial_ge   = (trial >= {1'b0, den_reg});
    assign trial_diff = trial - {1'b0, den_reg};

    // Sequencer and datapath
    always_comb
    begin
        state_next        = state_reg;
        iter_next         = iter_reg;
        mul_a_next        = mul_a_reg;
        mul_b_next        = mul_b_reg;
        nsh_next          = nsh_reg;
        dsh_next          = dsh_reg;
        num_next          = num_reg;
        den_next          = den_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        ok_next           = ok_reg;
        out_valid_next    = out_valid_reg;
        jitter_value_next = jitter_value_reg;
        valid_res_next    = valid_res_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    ok_next  = job_ok;
                    quo_next = '0;
                    if (job_ok)
                    begin
                        // numerator dev*n<<16, denominator (n-2)*total; absolute mode takes n and total as 1
                        mul_a_next = j_abs ? CNT_W'(1) : j_cnt;
                        mul_b_next = j_cnt - CNT_W'(2);
                        nsh_next   = NUM_W'(j_dev) << FRAC_BITS;
                        dsh_next   = j_abs ? DEN_W'(1) : DEN_W'(pt_fin);
                        num_next   = '0;
                        den_next   = '0;
                        iter_next  = ITER_W'(CNT_W - 1);
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL:
            begin
                if (mul_a_reg[0])
                begin
                    num_next = num_reg + nsh_reg;
                end
                if (mul_b_reg[0])
                begin
                    den_next = den_reg + dsh_reg;
                end
                nsh_next   = nsh_reg << 1;
                dsh_next   = dsh_reg << 1;
                mul_a_next = mul_a_reg >> 1;
                mul_b_next = mul_b_reg >> 1;
                if (iter_reg == '0)
                begin
                    iter_next  = ITER_W'(NUM_W - 1);
                    rem_next   = '0;
                    quo_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    iter_next = iter_reg - ITER_W'(1);
                end
            end
            ST_DIV:
            begin
                rem_next = trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], trial_ge};
                num_next = num_reg << 1;
                if (iter_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    iter_next = iter_reg - ITER_W'(1);
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    // saturate quotient to the output width; zero for a job that is not valid
                    if (!ok_reg)
                    begin
                        jitter_value_next = '0;
                    end
                    else if (|quo_reg[NUM_W-1:OUT_W])
                    begin
                        jitter_value_next = '1;
                    end
                    else
                    begin
                        jitter_value_next = quo_reg[OUT_W-1:0];
                    end
                    valid_res_next = ok_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        iter_reg         <= iter_next;
        mul_a_reg        <= mul_a_next;
        mul_b_reg        <= mul_b_next;
        nsh_reg          <= nsh_next;
        dsh_reg          <= dsh_next;
        num_reg          <= num_next;
        den_reg          <= den_next;
        rem_reg          <= rem_next;
        quo_reg          <= quo_next;
        ok_reg           <= ok_next;
        jitter_value_reg <= jitter_value_next;
        valid_res_reg    <= valid_res_next;
    end

    assign out_valid    = out_valid_reg;
    assign jitter_value = jitter_value_reg;
    assign valid_res    = valid_res_reg;

endmodule

// ===== rtl/ddp_period_jitter.sv =====
// DDP period jitter: one period word per cycle; one result per sequence.
// Throughput: one period word per cycle while the job queue has room.
// After the last word, the job passes through the shift-add products (CNT_W steps)
// and the restoring divider (NUM_W steps) before the result register.
// The two-entry job queue holds finished sequences while the divider runs.
// Reset (rst_n, asynchronous, active low) clears the totals and restores the configuration register defaults.
module ddp_period_jitter #(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_COUNT   = 1048576
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ddpj_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_BITS-1:0]         cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [SAMPLE_BITS-1:0]         period,
    input  logic                           missing,
    input  logic                           last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ddpj_pkg::OUT_W-1:0]     jitter_value,
    output logic                           valid_res
);
    import ddpj_pkg::*;

    localparam int CNT_W   = $clog2(MAX_COUNT + 2);
    localparam int DEV_W   = SAMPLE_BITS + 2 + $clog2(MAX_COUNT);
    localparam int PT_W    = SAMPLE_BITS + 1 + $clog2(MAX_COUNT);
    localparam int NUM_RAW = DEV_W + CNT_W + FRAC_BITS;
    localparam int NUM_W   = (NUM_RAW > OUT_W) ? NUM_RAW : OUT_W + 1;
    localparam int DEN_W   = CNT_W + PT_W;
    localparam int JOB_W   = 2 + CNT_W + DEV_W + PT_W + SAMPLE_BITS;

    logic [SAMPLE_BITS-1:0] min_period_reg, max_period_reg;
    logic                   absolute_mode_reg, drop_missing_reg;
    mode_t                  mode;

    logic                   q_push, q_full, q_valid, q_ready;
    logic [JOB_W-1:0]       q_push_data, q_pop_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_period_reg    <= '0;
            max_period_reg    <= '1;
            absolute_mode_reg <= 1'b0;
            drop_missing_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MIN_PERIOD:    min_period_reg    <= cfg_data;
                CFG_MAX_PERIOD:    max_period_reg    <= cfg_data;
                CFG_ABSOLUTE_MODE: absolute_mode_reg <= cfg_data[0];
                CFG_DROP_MISSING:  drop_missing_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign mode.absolute_mode = absolute_mode_reg;
    assign mode.drop_missing  = drop_missing_reg;

    // Accumulating front end
    ddpj_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_COUNT   (MAX_COUNT),
        .CNT_W       (CNT_W),
        .DEV_W       (DEV_W),
        .PT_W        (PT_W),
        .JOB_W       (JOB_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .period     (period),
        .missing    (missing),
        .last       (last),
        .min_period (min_period_reg),
        .max_period (max_period_reg),
        .mode       (mode),
        .q_push     (q_push),
        .q_data     (q_push_data),
        .q_full     (q_full)
    );

    // Job queue
    ddpj_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_data  (q_pop_data)
    );

    // Dividing back end
    ddpj_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W),
        .DEV_W       (DEV_W),
        .PT_W        (PT_W),
        .NUM_W       (NUM_W),
        .DEN_W       (DEN_W),
        .JOB_W       (JOB_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_data       (q_pop_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .jitter_value (jitter_value),
        .valid_res    (valid_res)
    );

endmodule
